// ===== design/smcn_pkg.sv =====
// Shared types and constants for the serpentine masked cell numbering block.
// Used by the top level, the row walker, the RAM and the checker; depends on nothing.
package smcn_pkg;

  // default raster size
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  // field widths
  localparam int ROW_W   = 9;
  localparam int NUM_W   = 32;
  localparam int TOT_W   = 17;
  localparam int OFF_W   = 2;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // register reset values
  localparam logic [ROW_W-1:0] RST_ROWS     = 9'd256;
  localparam logic [ROW_W-1:0] RST_COLS     = 9'd256;
  localparam logic [NUM_W-1:0] RST_NO_VALUE = 32'hFFFF_D8F1;
  localparam logic [NUM_W-1:0] RST_BASE     = 32'h0000_0000;

  // shift codes of the neighbour test; both remaining patterns mean minus one
  localparam logic [OFF_W-1:0] OFF_NONE = 2'b00;
  localparam logic [OFF_W-1:0] OFF_PLUS = 2'b01;

  // operation codes
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_LOOKUP   = 2'd2
  } op_e;

  // register indexes, byte address is four times the index
  typedef enum logic [2:0] {
    REG_ROWS     = 3'd0,
    REG_COLS     = 3'd1,
    REG_ROW_OFF  = 3'd2,
    REG_COL_OFF  = 3'd3,
    REG_NO_VALUE = 3'd4,
    REG_BASE     = 3'd5
  } reg_e;

  // control from the sequencer to the row walker
  typedef struct packed {
    logic             load;
    logic [ROW_W-1:0] len;
    logic             gate_a;
    logic             ok_b;
    logic [OFF_W-1:0] col_off;
  } walk_ctrl_t;

  // status from the row walker
  typedef struct packed {
    logic             done;
    logic [ROW_W-1:0] cnt;
    logic             last;
  } walk_stat_t;

endpackage

// ===== design/smcn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on smcn_pkg for default sizes only.
module smcn_ram import smcn_pkg::*; #(
  parameter int WIDTH = DEF_MAX_COLS,
  parameter int DEPTH = DEF_MAX_ROWS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/smcn_walk.sv =====
// Row walker: builds the qualifying-cell vector of one row from two mask rows
// and counts it one column per cycle. Depends on smcn_pkg.
module smcn_walk import smcn_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  walk_ctrl_t          ctrl_i,
  input  logic [ROW_W-1:0]    eff_cols_i,
  input  logic [MAX_COLS-1:0] word_a_i,
  input  logic [MAX_COLS-1:0] word_b_i,
  output walk_stat_t          stat_o
);

  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] merged;
  logic [MAX_COLS-1:0] shifted;
  logic [MAX_COLS-1:0] qual;
  logic [MAX_COLS-1:0] qv_q;
  logic [ROW_W-1:0]    rem_q;
  logic [ROW_W-1:0]    cnt_q;
  logic                last_q;

  // columns beyond the effective width read as outside
  always_comb begin
    for (int k = 0; k < MAX_COLS; k++) begin
      col_mask[k] = (32'(k) < 32'(eff_cols_i));
    end
  end

  // cell row and shifted row, then the column shift
  always_comb begin
    merged = (word_a_i & col_mask) | (ctrl_i.ok_b ? (word_b_i & col_mask) : '0);
    case (ctrl_i.col_off)
      OFF_NONE: shifted = merged;
      OFF_PLUS: shifted = merged >> 1;
      default:  shifted = merged << 1;
    endcase
    qual    = (merged | shifted) & col_mask;
    // first column never qualifies
    qual[0] = 1'b0;
    if (!ctrl_i.gate_a) begin
      qual = '0;
    end
  end

  // walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else if (ctrl_i.load) begin
      rem_q  <= ctrl_i.len;
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else if (rem_q != '0) begin
      rem_q  <= rem_q - 1'b1;
      cnt_q  <= cnt_q + ROW_W'(qv_q[0]);
      last_q <= qv_q[0];
    end
  end

  // vector shift line, lowest column first
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      qv_q <= qual;
    end else if (rem_q != '0) begin
      qv_q <= {1'b0, qv_q[MAX_COLS-1:1]};
    end
  end

  always_comb begin
    stat_o.done = (rem_q == '0);
    stat_o.cnt  = cnt_q;
    stat_o.last = last_q;
  end

endmodule

// ===== design/serpentine_masked_cell_numbering.sv =====
// Serpentine masked cell numbering, top level: register port, sequencer and the two RAMs.
// Depends on smcn_pkg, smcn_ram and smcn_walk.
//
// The basin mask sits in a RAM of MAX_ROWS words of MAX_COLS bits, the running row totals
// in a RAM of MAX_ROWS words of 17 bits. After reset the mask RAM is cleared one row per
// cycle with input stalled; register writes are taken meanwhile. An in-range load is a
// read-modify-write of one mask row through S_LDRD and S_LDWR, with input stalled. A
// lookup reads the cell's row and its shifted neighbour row through the single mask read
// port, then the row walker counts one column per cycle up to the cell's column. A
// finalize does the same for each row over the effective width. The next item is accepted
// while a result still waits on the output register.
module serpentine_masked_cell_numbering import smcn_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              operation_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [ROW_W-1:0]        col_i,
  input  logic                    mask_bit_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [NUM_W-1:0] cell_number_o,
  output logic                    is_numbered_o,
  output logic [TOT_W-1:0]        total_cells_o,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam int RowAw = $clog2(MAX_ROWS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LDRD, S_LDWR, S_RDA, S_RDB, S_BUILD,
    S_WALK, S_FWR, S_LIDX, S_LNUM, S_OUT
  } state_e;

  state_e                  state_q;
  logic [RowAw-1:0]        clr_q;
  logic [1:0]              op_q;
  logic [ROW_W-1:0]        cur_q;
  logic [ROW_W-1:0]        col_q;
  logic                    bit_q;
  logic [TOT_W-1:0]        run_q;
  logic [TOT_W-1:0]        total_q;
  logic                    ready_q;
  logic [NUM_W-1:0]        idx_q;
  logic [MAX_COLS-1:0]     wa_q;
  logic signed [NUM_W-1:0] res_num_q;
  logic                    res_isn_q;
  logic [TOT_W-1:0]        res_tot_q;
  logic                    out_valid_q;
  logic signed [NUM_W-1:0] out_num_q;
  logic                    out_isn_q;
  logic [TOT_W-1:0]        out_tot_q;

  // configuration registers
  logic [ROW_W-1:0]        rows_q;
  logic [ROW_W-1:0]        cols_q;
  logic signed [OFF_W-1:0] roff_q;
  logic signed [OFF_W-1:0] coff_q;
  logic signed [NUM_W-1:0] nvc_q;
  logic signed [NUM_W-1:0] base_q;

  logic                    in_xfer;
  logic                    cfg_wr;
  logic                    ld_in_range;
  logic [ROW_W-1:0]        rows_eff;
  logic [ROW_W-1:0]        cols_eff;
  logic [ROW_W:0]          roff_ext;
  logic [ROW_W:0]          row_b;
  logic [RowAw-1:0]        addr_a;
  logic [RowAw-1:0]        addr_b;
  logic [TOT_W-1:0]        run_new;

  // mask RAM and prefix RAM ports
  logic                    m_we;
  logic [RowAw-1:0]        m_waddr;
  logic [MAX_COLS-1:0]     m_wdata;
  logic                    m_re;
  logic [RowAw-1:0]        m_raddr;
  logic [MAX_COLS-1:0]     m_rdata;
  logic [MAX_COLS-1:0]     ld_word;
  logic                    p_we;
  logic                    p_re;
  logic [RowAw-1:0]        p_waddr;
  logic [RowAw-1:0]        p_raddr;
  logic [TOT_W-1:0]        p_rdata;

  walk_ctrl_t              wctrl;
  walk_stat_t              wstat;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // effective raster size
  assign rows_eff = (32'(rows_q) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : rows_q;
  assign cols_eff = (32'(cols_q) > MAX_COLS) ? ROW_W'(MAX_COLS) : cols_q;

  assign ld_in_range = (row_i != '0) && (32'(row_i) <= MAX_ROWS) &&
                       (col_i != '0) && (32'(col_i) <= MAX_COLS);

  // row of the shifted neighbour
  always_comb begin
    if (roff_q == OFF_NONE) begin
      roff_ext = '0;
    end else if (roff_q == OFF_PLUS) begin
      roff_ext = (ROW_W+1)'(1);
    end else begin
      roff_ext = '1;
    end
  end

  assign row_b  = (ROW_W+1)'(cur_q) + roff_ext;
  assign addr_a = RowAw'(cur_q - 9'd1);
  assign addr_b = RowAw'(row_b - 10'd1);

  // odd rows count on from the previous row's total, even rows down from their own
  assign p_raddr = cur_q[0] ? RowAw'(cur_q - 9'd2) : RowAw'(cur_q - 9'd1);
  assign p_waddr = addr_a;
  assign run_new = run_q + TOT_W'(wstat.cnt);

  // mask row with the loaded bit replaced
  always_comb begin
    for (int k = 0; k < MAX_COLS; k++) begin
      ld_word[k] = (32'(k) + 32'd1 == 32'(col_q)) ? bit_q : m_rdata[k];
    end
  end

  // RAM access per state
  always_comb begin
    m_we    = 1'b0;
    m_waddr = addr_a;
    m_wdata = ld_word;
    m_re    = 1'b0;
    m_raddr = addr_a;
    p_re    = 1'b0;
    p_we    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wdata = '0;
      end
      S_LDRD: m_re = 1'b1;
      S_LDWR: m_we = 1'b1;
      S_RDA: begin
        m_re = 1'b1;
        p_re = (op_q == OP_LOOKUP);
      end
      S_RDB: begin
        m_re    = 1'b1;
        m_raddr = addr_b;
      end
      S_FWR: p_we = 1'b1;
      default: ;
    endcase
  end

  // walker control
  always_comb begin
    wctrl.load    = (state_q == S_BUILD);
    wctrl.len     = (op_q == OP_FINALIZE) ? cols_eff : col_q;
    wctrl.gate_a  = (cur_q >= 9'd2) && (cur_q <= rows_eff);
    wctrl.ok_b    = (row_b >= 10'd1) && (row_b <= (ROW_W+1)'(rows_eff));
    wctrl.col_off = coff_q;
  end

  smcn_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  smcn_ram #(
    .WIDTH (TOT_W),
    .DEPTH (MAX_ROWS)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (run_new),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  smcn_walk #(
    .MAX_COLS (MAX_COLS)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (wctrl),
    .eff_cols_i (cols_eff),
    .word_a_i   (wa_q),
    .word_b_i   (m_rdata),
    .stat_o     (wstat)
  );

  // sequencer, result registers and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      op_q        <= '0;
      cur_q       <= '0;
      col_q       <= '0;
      bit_q       <= 1'b0;
      run_q       <= '0;
      total_q     <= '0;
      ready_q     <= 1'b0;
      idx_q       <= '0;
      wa_q        <= '0;
      res_num_q   <= '0;
      res_isn_q   <= 1'b0;
      res_tot_q   <= '0;
      out_valid_q <= 1'b0;
      out_num_q   <= '0;
      out_isn_q   <= 1'b0;
      out_tot_q   <= '0;
      rows_q      <= RST_ROWS;
      cols_q      <= RST_COLS;
      roff_q      <= OFF_NONE;
      coff_q      <= OFF_NONE;
      nvc_q       <= RST_NO_VALUE;
      base_q      <= RST_BASE;
    end else begin
      // result taken downstream
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == RowAw'(MAX_ROWS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            op_q  <= operation_i;
            // finalize walks from the first row
            cur_q <= (operation_i == OP_FINALIZE) ? 9'd1 : row_i;
            col_q <= col_i;
            bit_q <= mask_bit_i;
            case (operation_i)
              OP_LOAD: begin
                ready_q <= 1'b0;
                if (ld_in_range) begin
                  state_q <= S_LDRD;
                end
              end
              OP_FINALIZE: begin
                run_q <= '0;
                if (rows_eff == '0) begin
                  // empty raster
                  ready_q   <= 1'b1;
                  total_q   <= '0;
                  res_num_q <= '0;
                  res_isn_q <= 1'b0;
                  res_tot_q <= '0;
                  state_q   <= S_OUT;
                end else begin
                  state_q <= S_RDA;
                end
              end
              OP_LOOKUP: begin
                if (!ready_q) begin
                  res_num_q <= nvc_q;
                  res_isn_q <= 1'b0;
                  res_tot_q <= '0;
                  state_q   <= S_OUT;
                end else begin
                  state_q <= S_RDA;
                end
              end
              default: ;
            endcase
          end
        end
        S_LDRD: state_q <= S_LDWR;
        S_LDWR: state_q <= S_IDLE;
        S_RDA:  state_q <= S_RDB;
        S_RDB: begin
          wa_q    <= m_rdata;
          state_q <= S_BUILD;
        end
        S_BUILD: state_q <= S_WALK;
        S_WALK: begin
          if (wstat.done) begin
            state_q <= (op_q == OP_FINALIZE) ? S_FWR : S_LIDX;
          end
        end
        S_FWR: begin
          run_q <= run_new;
          if (cur_q == rows_eff) begin
            total_q   <= run_new;
            ready_q   <= 1'b1;
            res_num_q <= '0;
            res_isn_q <= 1'b0;
            res_tot_q <= run_new;
            state_q   <= S_OUT;
          end else begin
            cur_q   <= cur_q + 1'b1;
            state_q <= S_RDA;
          end
        end
        S_LIDX: begin
          if (cur_q[0]) begin
            idx_q <= NUM_W'(p_rdata) + NUM_W'(wstat.cnt);
          end else begin
            idx_q <= NUM_W'(p_rdata) - NUM_W'(wstat.cnt) + 32'd1;
          end
          state_q <= S_LNUM;
        end
        S_LNUM: begin
          // the last column walked is the queried cell
          res_num_q <= wstat.last ? (idx_q + base_q) : nvc_q;
          res_isn_q <= wstat.last;
          res_tot_q <= total_q;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_num_q   <= res_num_q;
            out_isn_q   <= res_isn_q;
            out_tot_q   <= res_tot_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // register writes; size or shift changes invalidate the counts
      if (cfg_wr) begin
        case (paddr[PADDR_W-1:2])
          REG_ROWS: begin
            rows_q  <= pwdata[ROW_W-1:0];
            ready_q <= 1'b0;
          end
          REG_COLS: begin
            cols_q  <= pwdata[ROW_W-1:0];
            ready_q <= 1'b0;
          end
          REG_ROW_OFF: begin
            roff_q  <= pwdata[OFF_W-1:0];
            ready_q <= 1'b0;
          end
          REG_COL_OFF: begin
            coff_q  <= pwdata[OFF_W-1:0];
            ready_q <= 1'b0;
          end
          REG_NO_VALUE: nvc_q  <= pwdata;
          REG_BASE:     base_q <= pwdata;
          default: ;
        endcase
      end
    end
  end

  // register read-back
  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_ROWS:     prdata = PDATA_W'(rows_q);
      REG_COLS:     prdata = PDATA_W'(cols_q);
      REG_ROW_OFF:  prdata = {30'b0, roff_q};
      REG_COL_OFF:  prdata = {30'b0, coff_q};
      REG_NO_VALUE: prdata = nvc_q;
      REG_BASE:     prdata = base_q;
      default:      prdata = '0;
    endcase
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cell_number_o = out_num_q;
  assign is_numbered_o = out_isn_q;
  assign total_cells_o = out_tot_q;

endmodule

// ===== design/smcn_checker.sv =====
// Port-level checker for the serpentine masked cell numbering block, bound to the top.
// Depends on smcn_pkg for the operation codes.
module smcn_checker import smcn_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [1:0]              operation_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [NUM_W-1:0] cell_number_o,
  input logic                    is_numbered_o,
  input logic [TOT_W-1:0]        total_cells_o
);

  // the clearing pass holds input off as reset is released
  a_clear_stalls: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input not stalled at the start of the clearing pass");

  // a load transfer never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == OP_LOAD && !out_valid_o
      |=> !out_valid_o)
    else $error("result appeared after a load");

  // finalize always stalls the input in the cycle after its transfer
  a_finalize_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == OP_FINALIZE |=> in_stall_o)
    else $error("finalize did not occupy the block");

  // a result only follows work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_number_o) &&
      $stable(is_numbered_o) && $stable(total_cells_o))
    else $error("stalled result changed");

endmodule

bind serpentine_masked_cell_numbering smcn_checker u_smcn_checker (.*);

// ===== tb/cell_number_checker.sv =====
// Checker for the serpentine masked cell numbering block: keeps its own copy of the mask,
// the row totals and the registers, predicts every result and compares it on transfer.
// Depends on smcn_pkg.
module cell_number_checker import smcn_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input channel
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [1:0]              operation_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [ROW_W-1:0]        col_i,
  input  logic                    mask_bit_i,
  // result channel
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [NUM_W-1:0] cell_number_i,
  input  logic                    is_numbered_i,
  input  logic [TOT_W-1:0]        total_cells_i,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  input  logic                    pready,
  // status to the testbench top
  output int                      due_count_o,
  output int                      fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             numbered;
    logic [TOT_W-1:0] total;
  } cell_answer_t;

  // answers still owed by the block, oldest first
  cell_answer_t     answers_due[$];

  // mirrored state of the block
  bit               basin [MAX_ROWS][MAX_COLS];
  logic [TOT_W-1:0] row_totals [MAX_ROWS];
  bit               counts_valid;
  logic [ROW_W-1:0] rows_reg;
  logic [ROW_W-1:0] cols_reg;
  logic [OFF_W-1:0] row_off_reg;
  logic [OFF_W-1:0] col_off_reg;
  logic [NUM_W-1:0] no_value_reg;
  logic [NUM_W-1:0] base_reg;
  int               fails;

  // effective raster size, clipped to the store
  function automatic int used_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic int used_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  // both negative patterns mean a shift of minus one
  function automatic int shift_amount(logic [OFF_W-1:0] code);
    if (code == OFF_NONE) return 0;
    if (code == OFF_PLUS) return 1;
    return -1;
  endfunction

  // cells beyond the effective raster read as outside the basin
  function automatic bit inside_basin(int r, int c);
    if (r < 1 || r > used_rows() || c < 1 || c > used_cols()) return 1'b0;
    return basin[r-1][c-1];
  endfunction

  // beyond row and column one, a cell counts if it or a shifted neighbour is in the basin
  function automatic bit is_counted(int r, int c);
    int dr;
    int dc;
    dr = shift_amount(row_off_reg);
    dc = shift_amount(col_off_reg);
    if (r < 2 || c < 2 || r > used_rows() || c > used_cols()) return 1'b0;
    return inside_basin(r, c) || inside_basin(r, c + dc) || inside_basin(r + dr, c) ||
           inside_basin(r + dr, c + dc);
  endfunction

  function automatic logic [TOT_W-1:0] grand_total();
    if (!counts_valid || used_rows() < 1) return '0;
    return row_totals[used_rows()-1];
  endfunction

  // walk the raster and keep the running total at the end of each row
  function automatic void count_cells();
    logic [TOT_W-1:0] running;
    int               r;
    int               c;
    running = '0;
    for (r = 1; r <= used_rows(); r++) begin
      for (c = 2; c <= used_cols(); c++)
        if (is_counted(r, c)) running++;
      row_totals[r-1] = running;
    end
    counts_valid = 1'b1;
  endfunction

  // serpentine number: odd rows run left to right, even rows right to left
  function automatic cell_answer_t number_cell(int r, int c);
    cell_answer_t     ans;
    int               pos;
    int               k;
    logic [NUM_W-1:0] idx;
    ans.number   = no_value_reg;
    ans.numbered = 1'b0;
    ans.total    = grand_total();
    if (counts_valid && is_counted(r, c)) begin
      pos = 0;
      for (k = 2; k <= c; k++)
        if (is_counted(r, k)) pos++;
      if (r % 2 == 0)
        idx = NUM_W'(row_totals[r-1]) - NUM_W'(pos) + 1;
      else
        idx = NUM_W'(row_totals[r-2]) + NUM_W'(pos);
      ans.number   = idx + base_reg;
      ans.numbered = 1'b1;
    end
    return ans;
  endfunction

  function automatic void take_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    case (reg_e'(addr[PADDR_W-1:2]))
      REG_ROWS: begin
        rows_reg     = data[ROW_W-1:0];
        counts_valid = 1'b0;
      end
      REG_COLS: begin
        cols_reg     = data[ROW_W-1:0];
        counts_valid = 1'b0;
      end
      REG_ROW_OFF: begin
        row_off_reg  = data[OFF_W-1:0];
        counts_valid = 1'b0;
      end
      REG_COL_OFF: begin
        col_off_reg  = data[OFF_W-1:0];
        counts_valid = 1'b0;
      end
      REG_NO_VALUE: no_value_reg = data[NUM_W-1:0];
      REG_BASE:     base_reg = data[NUM_W-1:0];
      default: ;
    endcase
  endfunction

  // one accepted input transfer, with the answer it owes if any
  function automatic void take_item(logic [1:0] op, int r, int c, logic b);
    cell_answer_t ans;
    case (op)
      OP_LOAD: begin
        if (r >= 1 && r <= MAX_ROWS && c >= 1 && c <= MAX_COLS) basin[r-1][c-1] = b;
        counts_valid = 1'b0;
      end
      OP_FINALIZE: begin
        count_cells();
        ans.number   = '0;
        ans.numbered = 1'b0;
        ans.total    = grand_total();
        answers_due.push_back(ans);
      end
      OP_LOOKUP: answers_due.push_back(number_cell(r, c));
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // watch the register port and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    cell_answer_t want;
    int           r;
    int           c;
    if (!rst_ni) begin
      for (r = 0; r < MAX_ROWS; r++) begin
        row_totals[r] = '0;
        for (c = 0; c < MAX_COLS; c++) basin[r][c] = 1'b0;
      end
      counts_valid = 1'b0;
      rows_reg     = RST_ROWS;
      cols_reg     = RST_COLS;
      row_off_reg  = OFF_NONE;
      col_off_reg  = OFF_NONE;
      no_value_reg = RST_NO_VALUE;
      base_reg     = RST_BASE;
      fails        = 0;
      answers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) take_register(paddr, pwdata);
      // result transfer against the oldest answer owed
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual 0x%0h %0d %0d", $time,
                   cell_number_i, is_numbered_i, total_cells_i);
        end else begin
          want = answers_due.pop_front();
          check_field("cell_number", want.number, cell_number_i);
          check_field("is_numbered", 32'(want.numbered), 32'(is_numbered_i));
          check_field("total_cells", 32'(want.total), 32'(total_cells_i));
        end
      end
      if (in_valid_i && !in_stall_i) take_item(operation_i, int'(row_i), int'(col_i), mask_bit_i);
    end
    due_count_o  <= answers_due.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the serpentine masked cell numbering block: clock, reset, stimulus,
// register writes, result stalls, watchdog and verdict.
// Depends on smcn_pkg, the block and cell_number_checker.
module tb_top import smcn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS   = 900;
  // the slowest single item is a full-size finalize
  localparam int          WATCHDOG_LIMIT = 300000;
  localparam int          SETTLE_CYCLES  = 12;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int          STALL_NONE     = 0;
  localparam int          STALL_RANDOM   = 1;
  localparam int          STALL_RUNS     = 2;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              operation;
  logic [ROW_W-1:0]        row;
  logic [ROW_W-1:0]        col;
  logic                    mask_bit;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [NUM_W-1:0] cell_number;
  logic                    is_numbered;
  logic [TOT_W-1:0]        total_cells;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;
  int                      due_count;
  int                      fail_count;

  int items_sent   = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;
  int stall_span   = 0;
  int stall_mode   = STALL_NONE;

  serpentine_masked_cell_numbering u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .row_i         (row),
    .col_i         (col),
    .mask_bit_i    (mask_bit),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .cell_number_o (cell_number),
    .is_numbered_o (is_numbered),
    .total_cells_o (total_cells),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  cell_number_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .operation_i   (operation),
    .row_i         (row),
    .col_i         (col),
    .mask_bit_i    (mask_bit),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .cell_number_i (cell_number),
    .is_numbered_i (is_numbered),
    .total_cells_i (total_cells),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .due_count_o   (due_count),
    .fail_count_o  (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result stalls: quiet spans, random stalls and long stall runs
  initial out_stall <= 1'b0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(16, 160);
      stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
      out_stall  <= 1'b0;
    end else begin
      stall_span <= stall_span - 1;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        default:      out_stall <= (stall_span % 8 < 5);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transfer, sent in bursts with random gaps in between
  task automatic send_item(input logic [1:0] op, input int r, input int c, input logic b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    operation <= op;
    row       <= r[ROW_W-1:0];
    col       <= c[ROW_W-1:0];
    mask_bit  <= b;
    do @(posedge clk); while (in_stall);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // hold the sender until every owed answer is back, then let the block go idle
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup phase, access phase, then idle
  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int n_rows, input int n_cols, input logic [1:0] roff,
                           input logic [1:0] coff, input logic [31:0] no_value,
                           input logic [31:0] base);
    write_reg(REG_ROWS, 32'(n_rows));
    write_reg(REG_COLS, 32'(n_cols));
    write_reg(REG_ROW_OFF, 32'(roff));
    write_reg(REG_COL_OFF, 32'(coff));
    write_reg(REG_NO_VALUE, no_value);
    write_reg(REG_BASE, base);
  endtask

  // one setting: load a raster, finalize, then mostly lookups with some noise
  task automatic run_phase(input int idx);
    int          n_rows;
    int          n_cols;
    int          density;
    int          n_looks;
    int          pick;
    int          r;
    int          c;
    int          k;
    bit          wide;
    logic [31:0] base;
    wide = (idx == 3 || idx == 9);
    drain_results();
    if (wide) begin
      n_rows = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
      n_cols = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
      if (idx == 3) begin
        n_rows = 511;
        n_cols = 256;
      end
    end else begin
      n_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
      n_cols = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
      // empty rasters and the one-cell raster
      if (idx == 1) n_rows = 0;
      if (idx == 2) n_cols = 0;
      if (idx == 4) begin
        n_rows = 1;
        n_cols = 1;
      end
    end
    case ($urandom_range(0, 4))
      0:       base = 32'h7FFF_FFFF;
      1:       base = 32'hFFFF_FFFF;
      2:       base = 32'h8000_0000;
      3:       base = 32'h0000_0000;
      default: base = $urandom();
    endcase
    configure(n_rows, n_cols, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
              $urandom(), base);

    // mask contents: a few far cells on the full raster, every cell on a small one
    if (wide) begin
      for (k = 0; k < 12; k++)
        send_item(OP_LOAD, $urandom_range(250, 256), $urandom_range(250, 256),
                  1'($urandom_range(0, 1)));
    end else begin
      density = $urandom_range(0, 100);
      for (r = 1; r <= n_rows; r++)
        for (c = 1; c <= n_cols; c++)
          send_item(OP_LOAD, r, c, $urandom_range(1, 100) <= density);
    end
    send_item(OP_FINALIZE, $urandom_range(0, 511), $urandom_range(0, 511),
              1'($urandom_range(0, 1)));

    n_looks = wide ? 10 : $urandom_range(6, 24);
    for (k = 0; k < n_looks; k++) begin
      pick = wide ? 19 : $urandom_range(0, 19);
      if (pick == 0) begin
        // noise: any code, any field value
        send_item(2'($urandom_range(0, 3)), $urandom_range(0, 511), $urandom_range(0, 511),
                  1'($urandom_range(0, 1)));
      end else if (pick == 1) begin
        // a stray load drops the counts, sometimes a new finalize restores them
        send_item(OP_LOAD, $urandom_range(1, n_rows + 1), $urandom_range(1, n_cols + 1),
                  1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
          send_item(OP_FINALIZE, $urandom_range(0, 511), $urandom_range(0, 511),
                    1'($urandom_range(0, 1)));
      end else if (wide) begin
        r = $urandom_range(0, 1) ? $urandom_range(240, 256) : $urandom_range(1, 256);
        c = $urandom_range(0, 1) ? $urandom_range(240, 256) : $urandom_range(1, 256);
        send_item(OP_LOOKUP, r, c, 1'($urandom_range(0, 1)));
      end else begin
        send_item(OP_LOOKUP, $urandom_range(1, n_rows + 1), $urandom_range(1, n_cols + 1),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int first_random;
    int phase_no;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    operation <= OP_LOAD;
    row       <= '0;
    col       <= '0;
    mask_bit  <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // lookup before any finalize, then an unknown code
    send_item(OP_LOOKUP, 2, 2, 1'b0);
    send_item(OP_UNUSED, 511, 511, 1'b1);

    // small raster, right shift, base just below the wrap
    drain_results();
    configure(4, 5, OFF_NONE, OFF_PLUS, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    send_item(OP_LOAD, 1, 1, 1'b1);
    send_item(OP_LOAD, 2, 3, 1'b1);
    send_item(OP_LOAD, 3, 5, 1'b1);
    send_item(OP_LOAD, 4, 2, 1'b1);
    send_item(OP_LOAD, 300, 3, 1'b1);
    send_item(OP_LOAD, 0, 0, 1'b1);
    send_item(OP_LOAD, 256, 256, 1'b1);
    send_item(OP_FINALIZE, 0, 0, 1'b0);
    send_item(OP_LOOKUP, 2, 2, 1'b0);
    send_item(OP_LOOKUP, 2, 5, 1'b1);
    send_item(OP_LOOKUP, 3, 4, 1'b0);
    send_item(OP_LOOKUP, 3, 5, 1'b0);
    send_item(OP_LOOKUP, 4, 5, 1'b0);
    send_item(OP_LOOKUP, 4, 1, 1'b0);
    send_item(OP_LOOKUP, 1, 3, 1'b0);
    send_item(OP_LOOKUP, 5, 2, 1'b0);
    send_item(OP_LOOKUP, 3, 6, 1'b0);

    // both negative shift patterns, base at the top so numbers wrap
    drain_results();
    configure(4, 5, 2'b10, 2'b11, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_FINALIZE, 511, 511, 1'b1);
    send_item(OP_LOOKUP, 2, 2, 1'b0);
    send_item(OP_LOOKUP, 3, 3, 1'b0);
    send_item(OP_LOOKUP, 4, 5, 1'b0);
    send_item(OP_LOAD, 2, 2, 1'b0);
    send_item(OP_LOOKUP, 3, 3, 1'b0);

    // random settings until enough items have gone in
    first_random = items_sent;
    phase_no     = 0;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      phase_no++;
      run_phase(phase_no);
    end

    drain_results();
    if (fail_count == 0 && due_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/smcn_pkg.sv
design/smcn_ram.sv
design/smcn_walk.sv
design/serpentine_masked_cell_numbering.sv
design/smcn_checker.sv
tb/cell_number_checker.sv
tb/tb_top.sv
